FILE: rtl/dpfb_pkg.sv
// shared types, opcodes and defaults for the dual page frame buffer
package dpfb_pkg;

	localparam int DEF_PAGES   = 8;
	localparam int DEF_COLUMNS = 128;
	localparam int BYTE_W      = 8;

	localparam logic [3:0] OP_RD_BYTE = 4'd0;
	localparam logic [3:0] OP_WR_BYTE = 4'd1;
	localparam logic [3:0] OP_WR_PIX  = 4'd2;
	localparam logic [3:0] OP_RD_PIX  = 4'd3;
	localparam logic [3:0] OP_FILL    = 4'd4;
	localparam logic [3:0] OP_CLR_TMP = 4'd5;
	localparam logic [3:0] OP_COPY    = 4'd6;
	localparam logic [3:0] OP_OR      = 4'd7;
	localparam logic [3:0] OP_ANDNOT  = 4'd8;

	// decoded command class, out-of-range accesses fold into KIND_NONE
	typedef enum logic [3:0] {
		KIND_NONE,
		KIND_RD_BYTE,
		KIND_WR_BYTE,
		KIND_WR_PIX,
		KIND_RD_PIX,
		KIND_FILL,
		KIND_CLR_TMP,
		KIND_COPY,
		KIND_OR,
		KIND_ANDNOT
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic              buf_sel;
		logic              oor;
		logic [2:0]        bit_idx;
		logic              pixel_on;
		logic [BYTE_W-1:0] data;
	} cmd_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_RESP,
		B_WALK,
		B_DRAIN
	} bstate_t;

endpackage

FILE: rtl/dual_page_frame_buffer.sv
// top level of the dual page frame buffer: config register, front end and back end
//
// channel   | ports                                              | handshake
// ----------+----------------------------------------------------+---------------------------
// command   | opcode page column row data_in pixel_on            | beat taken when start & !busy
// result    | read_byte pixel_bit out_of_range buffer_selected   | one beat per command, on done
// config    | cfg_wr_en cfg_wr_data (target_buffer)              | written when cfg_wr_en
//
// byte and pixel commands are popped and read from the memory in the idle state, then answered
// and written back in the response state (read-modify-write through the single write port)
// whole-buffer commands walk every entry, one entry per cycle, then drain the last write
// the result beat appears on done in the cycle after the back end finishes a command
// after reset a clearing pass zeroes every entry of both buffers; busy is high
// throughout and config writes are still taken
// once clearing is over, busy rises only when the two-entry command queue is full;
// results cannot be held off
module dual_page_frame_buffer
	import dpfb_pkg::*;
#(
	parameter int PAGES   = DEF_PAGES,
	parameter int COLUMNS = DEF_COLUMNS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [3:0] opcode,
	input  logic [3:0] page,
	input  logic [7:0] column,
	input  logic [6:0] row,
	input  logic [7:0] data_in,
	input  logic       pixel_on,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	output logic       done,
	output logic [7:0] read_byte,
	output logic       pixel_bit,
	output logic       out_of_range,
	output logic       buffer_selected
);

	// address width of one buffer, pages by columns of bytes
	localparam int AW = $clog2(PAGES * COLUMNS);

	logic          target_buffer_q;
	logic          clearing;
	logic          pop;
	logic          q_valid;
	cmd_t          q_cmd;
	logic [AW-1:0] q_addr;

	// target buffer select: 1 screen, 0 temporary; resets to screen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			target_buffer_q <= 1'b1;
		else if (cfg_wr_en)
			target_buffer_q <= cfg_wr_data;
	end

	// front end decodes and range-checks, then queues the command
	dpfb_front #(
		.PAGES   (PAGES),
		.COLUMNS (COLUMNS),
		.AW      (AW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.page          (page),
		.column        (column),
		.row           (row),
		.data_in       (data_in),
		.pixel_on      (pixel_on),
		.target_buffer (target_buffer_q),
		.clearing      (clearing),
		.pop           (pop),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.q_addr        (q_addr)
	);

	// back end owns both memories and runs accesses and buffer walks
	dpfb_back #(
		.PAGES   (PAGES),
		.COLUMNS (COLUMNS),
		.AW      (AW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_cmd           (q_cmd),
		.q_addr          (q_addr),
		.pop             (pop),
		.clearing        (clearing),
		.done            (done),
		.read_byte       (read_byte),
		.pixel_bit       (pixel_bit),
		.out_of_range    (out_of_range),
		.buffer_selected (buffer_selected)
	);

endmodule

FILE: rtl/dpfb_front.sv
// front end: command decode, range checks and a two-entry command queue
module dpfb_front
	import dpfb_pkg::*;
#(
	parameter int PAGES   = DEF_PAGES,
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int AW      = $clog2(PAGES * COLUMNS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [3:0]        opcode,
	input  logic [3:0]        page,
	input  logic [7:0]        column,
	input  logic [6:0]        row,
	input  logic [7:0]        data_in,
	input  logic              pixel_on,
	input  logic              target_buffer,
	input  logic              clearing,
	input  logic              pop,
	output logic              q_valid,
	output cmd_t              q_cmd,
	output logic [AW-1:0]     q_addr
);

	localparam int ROWS = PAGES * 8;

	cmd_t          dec_cmd;
	logic [AW-1:0] dec_addr;
	logic          byte_ok;
	logic          pix_ok;
	logic [AW-1:0] byte_addr;
	logic [AW-1:0] pix_addr;
	logic          push;

	cmd_t          fifo_cmd_q  [2];
	logic [AW-1:0] fifo_addr_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    count_q;

	assign byte_ok   = (32'(page) < PAGES) && (32'(column) < COLUMNS);
	assign pix_ok    = (32'(row) < ROWS) && (32'(column) < COLUMNS);
	assign byte_addr = AW'(32'(page) * COLUMNS + 32'(column));
	assign pix_addr  = AW'(32'(row[6:3]) * COLUMNS + 32'(column));

	always_comb begin
		dec_cmd.kind     = KIND_NONE;
		dec_cmd.buf_sel  = target_buffer;
		dec_cmd.oor      = 1'b0;
		dec_cmd.bit_idx  = row[2:0];
		dec_cmd.pixel_on = pixel_on;
		dec_cmd.data     = data_in;
		dec_addr         = '0;
		case (opcode)
			OP_RD_BYTE: begin
				if (byte_ok) begin
					dec_cmd.kind = KIND_RD_BYTE;
					dec_addr     = byte_addr;
				end
			end
			OP_WR_BYTE: begin
				if (byte_ok) begin
					dec_cmd.kind = KIND_WR_BYTE;
					dec_addr     = byte_addr;
				end
			end
			OP_WR_PIX: begin
				if (pix_ok) begin
					dec_cmd.kind = KIND_WR_PIX;
					dec_addr     = pix_addr;
				end else begin
					dec_cmd.oor = 1'b1;
				end
			end
			OP_RD_PIX: begin
				if (pix_ok) begin
					dec_cmd.kind = KIND_RD_PIX;
					dec_addr     = pix_addr;
				end else begin
					dec_cmd.oor = 1'b1;
				end
			end
			OP_FILL:    dec_cmd.kind = KIND_FILL;
			OP_CLR_TMP: dec_cmd.kind = KIND_CLR_TMP;
			OP_COPY:    dec_cmd.kind = KIND_COPY;
			OP_OR:      dec_cmd.kind = KIND_OR;
			OP_ANDNOT:  dec_cmd.kind = KIND_ANDNOT;
			default:    dec_cmd.kind = KIND_NONE;
		endcase
	end

	assign busy    = (count_q == 2'd2) || clearing;
	assign push    = start && !busy;
	assign q_valid = (count_q != 2'd0);
	assign q_cmd   = fifo_cmd_q[rptr_q];
	assign q_addr  = fifo_addr_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_cmd_q[wptr_q]  <= dec_cmd;
			fifo_addr_q[wptr_q] <= dec_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (pop && q_valid)
				rptr_q <= ~rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop && q_valid);
		end
	end

endmodule

FILE: rtl/dpfb_back.sv
// back end: both buffer memories and the sequencer that executes commands
module dpfb_back
	import dpfb_pkg::*;
#(
	parameter int PAGES   = DEF_PAGES,
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int AW      = $clog2(PAGES * COLUMNS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cmd_t              q_cmd,
	input  logic [AW-1:0]     q_addr,
	output logic              pop,
	output logic              clearing,
	output logic              done,
	output logic [7:0]        read_byte,
	output logic              pixel_bit,
	output logic              out_of_range,
	output logic              buffer_selected
);

	localparam int          CELLS = PAGES * COLUMNS;
	localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

	logic [BYTE_W-1:0] scr_mem [CELLS];
	logic [BYTE_W-1:0] tmp_mem [CELLS];
	logic [BYTE_W-1:0] scr_rd_q;
	logic [BYTE_W-1:0] tmp_rd_q;

	bstate_t       state_q, state_d;
	logic [AW-1:0] cnt_q;
	logic          cnt_clr, cnt_inc;
	cmd_t          cur_q;
	logic [AW-1:0] cur_addr_q;
	logic          wr_pend_q, wr_pend_d;
	logic [AW-1:0] waddr_q;
	logic          load_cur;

	logic [AW-1:0]     rd_addr;
	logic              scr_we, tmp_we;
	logic [AW-1:0]     scr_waddr, tmp_waddr;
	logic [BYTE_W-1:0] scr_wdata, tmp_wdata;
	logic [BYTE_W-1:0] sel_byte;
	logic [BYTE_W-1:0] mask;
	logic [BYTE_W-1:0] pix_byte;
	logic              done_d;

	logic done_q;
	logic [7:0] read_byte_q;
	logic pixel_bit_q, oor_q, bufsel_q;

	assign sel_byte = cur_q.buf_sel ? scr_rd_q : tmp_rd_q;
	assign mask     = BYTE_W'(1) << cur_q.bit_idx;
	assign pix_byte = cur_q.pixel_on ? (sel_byte | mask) : (sel_byte & ~mask);
	assign clearing = (state_q == B_CLEAR);

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		load_cur  = 1'b0;
		cnt_clr   = 1'b0;
		cnt_inc   = 1'b0;
		wr_pend_d = 1'b0;
		done_d    = 1'b0;
		rd_addr   = q_addr;
		scr_we    = 1'b0;
		tmp_we    = 1'b0;
		scr_waddr = waddr_q;
		tmp_waddr = waddr_q;
		scr_wdata = '0;
		tmp_wdata = '0;

		// trailing write of a buffer walk, one entry behind the read
		if (wr_pend_q) begin
			case (cur_q.kind)
				KIND_FILL: begin
					scr_we    = 1'b1;
					scr_wdata = cur_q.data;
				end
				KIND_CLR_TMP: begin
					tmp_we    = 1'b1;
					tmp_wdata = '0;
				end
				KIND_COPY: begin
					scr_we    = 1'b1;
					scr_wdata = tmp_rd_q;
				end
				KIND_OR: begin
					scr_we    = 1'b1;
					scr_wdata = scr_rd_q | tmp_rd_q;
				end
				KIND_ANDNOT: begin
					scr_we    = 1'b1;
					scr_wdata = scr_rd_q & ~tmp_rd_q;
				end
				default: ;
			endcase
		end

		case (state_q)
			B_CLEAR: begin
				scr_we    = 1'b1;
				tmp_we    = 1'b1;
				scr_waddr = cnt_q;
				tmp_waddr = cnt_q;
				if (cnt_q == LAST) begin
					cnt_clr = 1'b1;
					state_d = B_IDLE;
				end else begin
					cnt_inc = 1'b1;
				end
			end
			B_IDLE: begin
				if (q_valid) begin
					pop      = 1'b1;
					load_cur = 1'b1;
					if (q_cmd.kind inside {KIND_FILL, KIND_CLR_TMP, KIND_COPY,
							KIND_OR, KIND_ANDNOT})
						state_d = B_WALK;
					else
						state_d = B_RESP;
				end
			end
			B_RESP: begin
				done_d  = 1'b1;
				state_d = B_IDLE;
				if (cur_q.kind == KIND_WR_BYTE || cur_q.kind == KIND_WR_PIX) begin
					scr_we    = cur_q.buf_sel;
					tmp_we    = !cur_q.buf_sel;
					scr_waddr = cur_addr_q;
					tmp_waddr = cur_addr_q;
					scr_wdata = (cur_q.kind == KIND_WR_BYTE) ? cur_q.data : pix_byte;
					tmp_wdata = scr_wdata;
				end
			end
			B_WALK: begin
				rd_addr   = cnt_q;
				wr_pend_d = 1'b1;
				if (cnt_q == LAST) begin
					cnt_clr = 1'b1;
					state_d = B_DRAIN;
				end else begin
					cnt_inc = 1'b1;
				end
			end
			B_DRAIN: begin
				done_d  = 1'b1;
				state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (scr_we)
			scr_mem[scr_waddr] <= scr_wdata;
		scr_rd_q <= scr_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (tmp_we)
			tmp_mem[tmp_waddr] <= tmp_wdata;
		tmp_rd_q <= tmp_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			cnt_q     <= '0;
			wr_pend_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			wr_pend_q <= wr_pend_d;
			done_q    <= done_d;
			if (cnt_clr)
				cnt_q <= '0;
			else if (cnt_inc)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_cur) begin
			cur_q      <= q_cmd;
			cur_addr_q <= q_addr;
		end
		waddr_q <= cnt_q;
		if (done_d) begin
			read_byte_q <= (cur_q.kind == KIND_RD_BYTE) ? sel_byte : '0;
			pixel_bit_q <= (cur_q.kind == KIND_RD_PIX) ? sel_byte[cur_q.bit_idx] : 1'b0;
			oor_q       <= cur_q.oor;
			bufsel_q    <= cur_q.buf_sel;
		end
	end

	assign done            = done_q;
	assign read_byte       = read_byte_q;
	assign pixel_bit       = pixel_bit_q;
	assign out_of_range    = oor_q;
	assign buffer_selected = bufsel_q;

endmodule

FILE: tb/dual_page_frame_buffer_tb.sv
// self-checking testbench for the dual page frame buffer: directed and random command beats
`timescale 1ns / 100ps

module dual_page_frame_buffer_tb
	import dpfb_pkg::*;
();

	// geometry follows the package defaults, passed explicitly to the block
	localparam int PAGES       = DEF_PAGES;
	localparam int COLUMNS     = DEF_COLUMNS;
	localparam int ROWS        = PAGES * 8;
	localparam int CELLS       = PAGES * COLUMNS;
	// a whole-buffer command walks every cell, plus the pop and drain states
	localparam int WALK_CYCLES = CELLS + 2;
	// longest honest silence: clearing pass or a walk with the queue full, taken with margin
	localparam int STALL_LIMIT = 4 * WALK_CYCLES + 500;
	localparam int REPORT_LIMIT = 10;
	// top of the unused opcode space
	localparam logic [3:0] OP_HIGHEST = 4'hF;
	// target_buffer encodings
	localparam bit TGT_TEMP   = 1'b0;
	localparam bit TGT_SCREEN = 1'b1;

	// one command beat, same field order and widths as the ports
	typedef struct packed {
		logic [3:0] opcode;
		logic [3:0] page;
		logic [7:0] column;
		logic [6:0] row;
		logic [7:0] data;
		logic       pixel_on;
	} fb_cmd_t;

	// one result beat
	typedef struct packed {
		logic [7:0] read_byte;
		logic       pixel_bit;
		logic       out_of_range;
		logic       buffer_selected;
	} fb_readback_t;

	// an expected result together with the command that caused it, for messages
	typedef struct packed {
		fb_cmd_t      cmd;
		fb_readback_t rb;
	} fb_expect_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start;
	logic       busy;
	logic [3:0] opcode;
	logic [3:0] page;
	logic [7:0] column;
	logic [6:0] row;
	logic [7:0] data_in;
	logic       pixel_on;
	logic       cfg_wr_en;
	logic       cfg_wr_data;
	logic       done;
	logic [7:0] read_byte;
	logic       pixel_bit;
	logic       out_of_range;
	logic       buffer_selected;

	// mirror of the block's state, updated as each command beat is accepted
	logic [7:0] screen_mirror [0:CELLS-1];
	logic [7:0] temp_mirror   [0:CELLS-1];
	bit         target_mirror;

	// results still owed by the block, oldest first
	fb_expect_t pending_readbacks [$];

	int error_count;
	int stall_cycles;
	int results_checked;
	int n_items, n_byte, n_pixel, n_offscreen, n_whole, n_unused, n_cfg_writes;

	dual_page_frame_buffer #(
		.PAGES   (PAGES),
		.COLUMNS (COLUMNS)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.page            (page),
		.column          (column),
		.row             (row),
		.data_in         (data_in),
		.pixel_on        (pixel_on),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.done            (done),
		.read_byte       (read_byte),
		.pixel_bit       (pixel_bit),
		.out_of_range    (out_of_range),
		.buffer_selected (buffer_selected)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// applies one command to the mirror and returns the result beat it should produce
	function automatic fb_readback_t predict_readback(input fb_cmd_t c);
		fb_readback_t r;
		bit          byte_ok;
		bit          pix_ok;
		int          byte_idx;
		int          pcell;
		int          i;
		logic [7:0]  cur;
		r = '0;
		r.buffer_selected = target_mirror;
		byte_ok = (c.page < PAGES) && (c.column < COLUMNS);
		pix_ok  = (c.row < ROWS) && (c.column < COLUMNS);
		byte_idx = int'(c.page) * COLUMNS + int'(c.column);
		// pixel row r sits in page r/8, bit r%8
		pcell   = (int'(c.row) >> 3) * COLUMNS + int'(c.column);
		case (c.opcode)
			OP_RD_BYTE: begin
				if (byte_ok)
					r.read_byte = target_mirror ? screen_mirror[byte_idx]
						: temp_mirror[byte_idx];
			end
			OP_WR_BYTE: begin
				if (byte_ok) begin
					if (target_mirror)
						screen_mirror[byte_idx] = c.data;
					else
						temp_mirror[byte_idx] = c.data;
				end
			end
			OP_WR_PIX: begin
				if (!pix_ok) begin
					r.out_of_range = 1'b1;
				end else begin
					cur = target_mirror ? screen_mirror[pcell] : temp_mirror[pcell];
					cur[c.row[2:0]] = c.pixel_on;
					if (target_mirror)
						screen_mirror[pcell] = cur;
					else
						temp_mirror[pcell] = cur;
				end
			end
			OP_RD_PIX: begin
				if (!pix_ok) begin
					r.out_of_range = 1'b1;
				end else begin
					cur = target_mirror ? screen_mirror[pcell] : temp_mirror[pcell];
					r.pixel_bit = cur[c.row[2:0]];
				end
			end
			// whole-buffer commands ignore the target and always land on the screen,
			// except the temp clear
			OP_FILL:    for (i = 0; i < CELLS; i++) screen_mirror[i] = c.data;
			OP_CLR_TMP: for (i = 0; i < CELLS; i++) temp_mirror[i] = '0;
			OP_COPY:    for (i = 0; i < CELLS; i++) screen_mirror[i] = temp_mirror[i];
			OP_OR:      for (i = 0; i < CELLS; i++) screen_mirror[i] |= temp_mirror[i];
			OP_ANDNOT:  for (i = 0; i < CELLS; i++) screen_mirror[i] &= ~temp_mirror[i];
			default: ;
		endcase
		return r;
	endfunction

	function automatic fb_cmd_t make_cmd(input logic [3:0] op, input logic [3:0] pg,
			input logic [7:0] col, input logic [6:0] rw, input logic [7:0] dat,
			input logic pon);
		fb_cmd_t c;
		c.opcode   = op;
		c.page     = pg;
		c.column   = col;
		c.row      = rw;
		c.data     = dat;
		c.pixel_on = pon;
		return c;
	endfunction

	// random command: every field starts fully random, then opcode and coordinates are
	// steered so that most accesses land in a small hot corner and hit earlier writes
	function automatic fb_cmd_t random_cmd();
		fb_cmd_t c;
		int      pick;
		int      zone;
		c = fb_cmd_t'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 4)
			c.opcode = 4'($urandom_range(OP_ANDNOT + 1, OP_HIGHEST));
		else if (pick < 14)
			c.opcode = 4'($urandom_range(OP_FILL, OP_ANDNOT));
		else if (pick < 40)
			c.opcode = OP_WR_BYTE;
		else if (pick < 60)
			c.opcode = OP_RD_BYTE;
		else if (pick < 80)
			c.opcode = OP_WR_PIX;
		else
			c.opcode = OP_RD_PIX;
		zone = $urandom_range(0, 9);
		if (zone < 6) begin
			// hot corner: first two pages, first eight columns
			c.page   = 4'($urandom_range(0, 1));
			c.column = 8'($urandom_range(0, 7));
			c.row    = 7'($urandom_range(0, 15));
		end else if (zone < 8) begin
			// bottom-right corner of the screen, just inside and just outside
			c.page   = 4'(PAGES - 1 + $urandom_range(0, 1));
			c.column = 8'(COLUMNS - 1 + $urandom_range(0, 1));
			c.row    = 7'(ROWS - 1 + $urandom_range(0, 1));
		end
		// otherwise keep the full random coordinates, often off screen
		return c;
	endfunction

	// drives one command beat and waits for it to be taken; start stays high on return
	// so that a following beat can go out back to back
	task automatic send_command(input fb_cmd_t c, input int idle_pct);
		fb_expect_t e;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		opcode   <= c.opcode;
		page     <= c.page;
		column   <= c.column;
		row      <= c.row;
		data_in  <= c.data;
		pixel_on <= c.pixel_on;
		do
			@(posedge clk);
		while (busy);
		// beat taken at this edge
		e.cmd = c;
		e.rb  = predict_readback(c);
		pending_readbacks.push_back(e);
		n_items++;
		if (c.opcode == OP_RD_BYTE || c.opcode == OP_WR_BYTE)
			n_byte++;
		else if (c.opcode == OP_RD_PIX || c.opcode == OP_WR_PIX)
			n_pixel++;
		else if (c.opcode >= OP_FILL && c.opcode <= OP_ANDNOT)
			n_whole++;
		else
			n_unused++;
		if (e.rb.out_of_range)
			n_offscreen++;
	endtask

	// stop sending and wait for every owed result; returns on a rising edge
	task automatic settle();
		start <= 1'b0;
		while (pending_readbacks.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// only called once the block is idle
	task automatic set_target_buffer(input bit tgt);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= tgt;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		target_mirror = tgt;
		n_cfg_writes++;
	endtask

	task automatic note_failure(input string msg);
		if (error_count < REPORT_LIMIT)
			$display("[%0t] %s", $realtime, msg);
		error_count++;
	endtask

	// byte access at the corners and beyond the edges, on the screen after reset
	task automatic test_byte_access();
		send_command(make_cmd(OP_WR_BYTE, 4'd0, 8'd0, 7'd0, 8'hFF, 1'b0), 0);
		send_command(make_cmd(OP_WR_BYTE, 4'(PAGES - 1), 8'(COLUMNS - 1), 7'd0, 8'hA5,
			1'b1), 0);
		send_command(make_cmd(OP_RD_BYTE, 4'd0, 8'd0, 7'd0, 8'h00, 1'b0), 0);
		send_command(make_cmd(OP_RD_BYTE, 4'(PAGES - 1), 8'(COLUMNS - 1), 7'd0, 8'h00,
			1'b0), 0);
		// page beyond the last one: write dropped, read gives zero, no flag
		send_command(make_cmd(OP_WR_BYTE, 4'hF, 8'd0, 7'd0, 8'h5A, 1'b0), 0);
		send_command(make_cmd(OP_RD_BYTE, 4'hF, 8'd0, 7'd0, 8'h00, 1'b0), 0);
		// column beyond the last one
		send_command(make_cmd(OP_RD_BYTE, 4'd0, 8'hFF, 7'h7F, 8'hFF, 1'b1), 0);
	endtask

	// pixel read-modify-write inside the byte written above, plus off-screen pixels
	task automatic test_pixel_access();
		send_command(make_cmd(OP_WR_PIX, 4'd0, 8'd0, 7'd0, 8'h00, 1'b0), 0);
		send_command(make_cmd(OP_RD_PIX, 4'd0, 8'd0, 7'd0, 8'h00, 1'b0), 0);
		send_command(make_cmd(OP_RD_PIX, 4'd0, 8'd0, 7'd1, 8'h00, 1'b0), 0);
		send_command(make_cmd(OP_WR_PIX, 4'd0, 8'(COLUMNS - 1), 7'(ROWS - 1), 8'h00,
			1'b1), 0);
		// rows past the bottom and columns past the right edge raise the flag
		send_command(make_cmd(OP_WR_PIX, 4'd0, 8'd0, 7'h7F, 8'h00, 1'b1), 0);
		send_command(make_cmd(OP_RD_PIX, 4'd0, 8'd200, 7'(ROWS), 8'h00, 1'b0), 0);
	endtask

	// unused opcodes change nothing and report only the target
	task automatic test_unused_opcodes();
		send_command(make_cmd(4'(OP_ANDNOT + 1), 4'hF, 8'hFF, 7'h7F, 8'hFF, 1'b1), 0);
		send_command(make_cmd(OP_HIGHEST, 4'hF, 8'hFF, 7'h7F, 8'hFF, 1'b1), 0);
	endtask

	// whole-buffer commands, with the temp buffer primed through the target switch
	task automatic test_whole_buffer_ops();
		settle();
		set_target_buffer(TGT_TEMP);
		send_command(make_cmd(OP_WR_BYTE, 4'd3, 8'd9, 7'd0, 8'h3C, 1'b0), 0);
		send_command(make_cmd(OP_WR_PIX, 4'd0, 8'd10, 7'd0, 8'h00, 1'b1), 0);
		settle();
		set_target_buffer(TGT_SCREEN);
		send_command(make_cmd(OP_FILL, 4'd0, 8'd0, 7'd0, 8'hFF, 1'b0), 0);
		send_command(make_cmd(OP_ANDNOT, 4'd0, 8'd0, 7'd0, 8'h00, 1'b0), 0);
		send_command(make_cmd(OP_RD_BYTE, 4'd3, 8'd9, 7'd0, 8'h00, 1'b0), 0);
		send_command(make_cmd(OP_OR, 4'd0, 8'd0, 7'd0, 8'h00, 1'b0), 0);
		send_command(make_cmd(OP_RD_BYTE, 4'd3, 8'd9, 7'd0, 8'h00, 1'b0), 0);
		send_command(make_cmd(OP_COPY, 4'd0, 8'd0, 7'd0, 8'h00, 1'b0), 0);
		send_command(make_cmd(OP_RD_BYTE, 4'd3, 8'd9, 7'd0, 8'h00, 1'b0), 0);
		send_command(make_cmd(OP_RD_PIX, 4'd0, 8'd10, 7'd0, 8'h00, 1'b0), 0);
		send_command(make_cmd(OP_CLR_TMP, 4'd0, 8'd0, 7'd0, 8'h00, 1'b0), 0);
		send_command(make_cmd(OP_FILL, 4'd0, 8'd0, 7'd0, 8'h00, 1'b0), 0);
	endtask

	// one phase of random traffic at a given target and sender idle rate
	task automatic test_random_traffic(input int count, input int idle_pct, input bit tgt);
		settle();
		set_target_buffer(tgt);
		repeat (count)
			send_command(random_cmd(), idle_pct);
	endtask

	// result checker: every done beat is matched against the oldest expectation
	always @(posedge clk) begin : readback_checker
		fb_expect_t want;
		if (arst_n && done) begin
			results_checked++;
			if (pending_readbacks.size() == 0) begin
				note_failure($sformatf({"result beat with nothing expected: ",
					"byte %02h pix %0b oor %0b sel %0b"},
					read_byte, pixel_bit, out_of_range, buffer_selected));
			end else begin
				want = pending_readbacks.pop_front();
				if (read_byte !== want.rb.read_byte || pixel_bit !== want.rb.pixel_bit ||
						out_of_range !== want.rb.out_of_range ||
						buffer_selected !== want.rb.buffer_selected)
					note_failure($sformatf({"op %0d pg %0d col %0d row %0d: expected byte %02h ",
						"pix %0b oor %0b sel %0b, got byte %02h pix %0b oor %0b sel %0b"},
						want.cmd.opcode, want.cmd.page, want.cmd.column, want.cmd.row,
						want.rb.read_byte, want.rb.pixel_bit, want.rb.out_of_range,
						want.rb.buffer_selected, read_byte, pixel_bit, out_of_range,
						buffer_selected));
			end
		end
	end

	// watchdog: cycles with neither a command beat nor a result beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_cycles <= 0;
		else if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin : watchdog
		wait (stall_cycles >= STALL_LIMIT);
		$display("no beat moved for %0d cycles, %0d results outstanding",
			stall_cycles, pending_readbacks.size());
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int i;
		start       <= 1'b0;
		opcode      <= '0;
		page        <= '0;
		column      <= '0;
		row         <= '0;
		data_in     <= '0;
		pixel_on    <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= 1'b0;
		// mirror of the reset state: both buffers zero, target is the screen
		for (i = 0; i < CELLS; i++) begin
			screen_mirror[i] = '0;
			temp_mirror[i]   = '0;
		end
		target_mirror = TGT_SCREEN;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// let the clearing pass run out before the first beat
		@(posedge clk);
		while (busy)
			@(posedge clk);

		test_byte_access();
		test_pixel_access();
		test_unused_opcodes();
		test_whole_buffer_ops();

		// sender mostly eager, then mostly idle, then never idle; target toggled each half
		test_random_traffic(67, 9, TGT_SCREEN);
		test_random_traffic(67, 9, TGT_TEMP);
		test_random_traffic(67, 78, TGT_SCREEN);
		test_random_traffic(67, 78, TGT_TEMP);
		test_random_traffic(66, 0, TGT_SCREEN);
		test_random_traffic(66, 0, TGT_TEMP);

		settle();
		// wait quietly to catch any stray result beat
		repeat (8) @(posedge clk);
		if (pending_readbacks.size() != 0)
			note_failure($sformatf("%0d expected results never arrived",
				pending_readbacks.size()));

		$display({"%0d commands, %0d results checked: %0d byte, %0d pixel ",
			"(%0d off screen), %0d whole-buffer, %0d unused"},
			n_items, results_checked, n_byte, n_pixel, n_offscreen, n_whole, n_unused);
		$display("%0d target buffer writes, sender idle rates 9%%, 78%% and none, %0d failures",
			n_cfg_writes, error_count);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: dual_page_frame_buffer.f
rtl/dpfb_pkg.sv
rtl/dpfb_front.sv
rtl/dpfb_back.sv
rtl/dual_page_frame_buffer.sv
tb/dual_page_frame_buffer_tb.sv
